[rtl/core/cudp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cudp_pkg
// Shared types and codes for the caption user-data parser.
// ----------------------------------------------------------------------------
package cudp_pkg;

    localparam int QueueDepth = 4;
    localparam int MaxRecords = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       top_first;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] format;
        logic [7:0] tag_byte;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic [1:0] status;
    } out_item_t;

    typedef enum logic [4:0] {
        PH_HDR, PH_DVD_FLAG, PH_DVD_SEG, PH_SCTE_CNT, PH_SCTE_PAIR, PH_TAIL,
        PH_A53_TYPE, PH_A53_FLAGS, PH_A53_SKIP, PH_A53_DATA, PH_A53_MARK,
        PH_SAT_HDR, PH_SAT_SKIP6, PH_SAT_T2, PH_SAT_PAD, PH_SAT_C1, PH_SAT_C2,
        PH_SAT_REP, PH_SAT_C3, PH_SAT_C4, PH_DONE_OK, PH_DONE_BAD
    } phase_t;

    localparam logic [1:0] KIND_DIRECT   = 2'd0;
    localparam logic [1:0] KIND_BUFFERED = 2'd1;
    localparam logic [1:0] KIND_BLKEND   = 2'd2;
    localparam logic [1:0] KIND_DONE     = 2'd3;

    localparam logic [2:0] FMT_DVD     = 3'd0;
    localparam logic [2:0] FMT_SCTE    = 3'd1;
    localparam logic [2:0] FMT_RECA    = 3'd2;
    localparam logic [2:0] FMT_RECB    = 3'd3;
    localparam logic [2:0] FMT_A53     = 3'd4;
    localparam logic [2:0] FMT_SAT     = 3'd5;
    localparam logic [2:0] FMT_0209    = 3'd6;
    localparam logic [2:0] FMT_UNKNOWN = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    localparam logic [7:0] TAG_FIELD1 = 8'h04;
    localparam logic [7:0] TAG_FIELD2 = 8'h05;

    function automatic out_item_t mk_rec(input logic [1:0] kind, input logic [2:0] fmt,
                                         input logic [7:0] tag, input logic [7:0] d1,
                                         input logic [7:0] d2, input logic [1:0] st);
        out_item_t r;
        r.kind        = kind;
        r.format      = fmt;
        r.tag_byte    = tag;
        r.first_data  = d1;
        r.second_data = d2;
        r.status      = st;
        return r;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[7-k] = v[k];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/cudp_parse.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cudp_parse
// Container parser: one byte per transfer, up to three records per byte.
// ----------------------------------------------------------------------------
module cudp_parse
    import cudp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,
    input  wire in_item_t  item,
    output out_item_t      recs [MaxRecords],
    output logic [1:0]     rec_count
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  fmt_reg, fmt_next;
    logic [3:0]  idx_reg, idx_next;
    logic [5:0]  pairs_reg, pairs_next;
    logic [25:0] buf_reg, buf_next;
    logic [4:0]  bits_reg, bits_next;
    logic        pat_reg, pat_next;
    logic        trunc_reg, trunc_next;
    logic        slot_reg, slot_next;
    logic [7:0]  sub_reg, sub_next;
    logic [7:0]  held_reg [3];
    logic [7:0]  held_next [3];

    always_comb
    begin
        logic [7:0] b;
        logic [7:0] h0;
        logic [1:0] n;
        logic [1:0] fn;
        logic       f;
        logic [1:0] st;
        b = item.data_byte;
        h0 = 8'h00;
        n = 2'd0;
        fn = 2'd0;
        f = 1'b0;
        st = ST_OK;
        phase_next = phase_reg;
        fmt_next = fmt_reg;
        idx_next = idx_reg;
        pairs_next = pairs_reg;
        buf_next = buf_reg;
        bits_next = bits_reg;
        pat_next = pat_reg;
        trunc_next = trunc_reg;
        slot_next = slot_reg;
        sub_next = sub_reg;
        held_next = held_reg;
        for (int i = 0; i < MaxRecords; i++)
        begin
            recs[i] = '0;
        end
        if (fire)
        begin
            unique case (phase_reg)
                PH_HDR:
                begin
                    if (idx_reg < 4'd3)
                    begin
                        held_next[idx_reg[1:0]] = b;
                        idx_next = idx_reg + 4'd1;
                    end
                    else
                    begin
                        idx_next = 4'd0;
                        if (held_reg[0] == 8'h43 && held_reg[1] == 8'h43)
                        begin
                            fmt_next = FMT_DVD;
                            phase_next = PH_DVD_FLAG;
                        end
                        else if (held_reg[0] == 8'h03)
                        begin
                            fmt_next = FMT_SCTE;
                            if (held_reg[1][6:0] == 7'h01)
                            begin
                                // count field sits in the top five bits of the third byte
                                pairs_next = {1'b0, held_reg[2][7:3]};
                                if (held_reg[2][7:3] == 5'd0)
                                begin
                                    recs[n] = mk_rec(KIND_BLKEND, fmt_next, 8'h00, 8'h00,
                                                     8'h00, ST_OK);
                                    n = n + 2'd1;
                                    buf_next = '0;
                                    bits_next = '0;
                                    phase_next = PH_DONE_OK;
                                end
                                else
                                begin
                                    buf_next = {15'd0, held_reg[2][2:0], b};
                                    bits_next = 5'd11;
                                    phase_next = PH_SCTE_PAIR;
                                end
                            end
                            else
                            begin
                                phase_next = PH_DONE_OK;
                            end
                        end
                        else if ((held_reg[0] == 8'hBB || held_reg[0] == 8'h99) &&
                                 held_reg[1] == 8'h02)
                        begin
                            fmt_next = (held_reg[0] == 8'hBB) ? FMT_RECA : FMT_RECB;
                            recs[n] = mk_rec(KIND_DIRECT, fmt_next, TAG_FIELD2, held_reg[2],
                                             b, ST_OK);
                            n = n + 2'd1;
                            phase_next = PH_TAIL;
                        end
                        else if (held_reg[0] == 8'h47 && held_reg[1] == 8'h41 &&
                                 held_reg[2] == 8'h39 && b == 8'h34)
                        begin
                            fmt_next = FMT_A53;
                            phase_next = PH_A53_TYPE;
                        end
                        else if (held_reg[0] == 8'h05 && held_reg[1] == 8'h02)
                        begin
                            fmt_next = FMT_SAT;
                            phase_next = PH_SAT_HDR;
                        end
                        else if (held_reg[0] == 8'h02 && held_reg[1] == 8'h09)
                        begin
                            fmt_next = FMT_0209;
                            phase_next = PH_TAIL;
                        end
                        else
                        begin
                            fmt_next = FMT_UNKNOWN;
                            phase_next = PH_DONE_OK;
                        end
                    end
                end
                PH_DVD_FLAG:
                begin
                    pat_next = b[7];
                    trunc_next = b[0];
                    pairs_next = {1'b0, b[5:1]} + {5'd0, b[0]};
                    slot_next = 1'b0;
                    idx_next = 4'd0;
                    phase_next = PH_DVD_SEG;
                end
                PH_DVD_SEG:
                begin
                    if (pairs_reg == 6'd0 && !slot_reg && idx_reg == 4'd0 &&
                        b[7:1] != 7'h7F)
                    begin
                        phase_next = PH_DONE_OK;
                    end
                    else
                    begin
                        held_next[idx_reg[1:0]] = b;
                        if (idx_reg < 4'd2)
                        begin
                            idx_next = idx_reg + 4'd1;
                        end
                        else
                        begin
                            idx_next = 4'd0;
                            h0 = held_next[0];
                            if (trunc_reg && pairs_reg == 6'd1 && slot_reg)
                            begin
                                phase_next = PH_DONE_OK;
                            end
                            else if (h0[7:1] != 7'h7F)
                            begin
                                phase_next = PH_DONE_BAD;
                            end
                            else
                            begin
                                recs[n] = mk_rec(KIND_DIRECT, fmt_reg,
                                                 (h0 == 8'hFF && slot_reg == !pat_reg) ?
                                                 TAG_FIELD1 : TAG_FIELD2,
                                                 held_next[1], held_next[2], ST_OK);
                                n = n + 2'd1;
                                if (slot_reg)
                                begin
                                    slot_next = 1'b0;
                                    if (pairs_reg != 6'd0)
                                    begin
                                        pairs_next = pairs_reg - 6'd1;
                                    end
                                end
                                else
                                begin
                                    slot_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_SCTE_PAIR, PH_SCTE_CNT:
                begin
                    // shift in MSB first; a 26-bit field completes at most once per byte
                    for (int k = 7; k >= 0; k--)
                    begin
                        if (phase_next == PH_SCTE_PAIR)
                        begin
                            buf_next = {buf_next[24:0], b[k]};
                            bits_next = bits_next + 5'd1;
                            if (bits_next == 5'd26)
                            begin
                                fn = buf_next[23:22];
                                if (fn == 2'd0)
                                begin
                                    recs[n] = mk_rec(KIND_BUFFERED, fmt_reg, 8'h00, 8'h00,
                                                     8'h00, ST_OK);
                                end
                                else
                                begin
                                    f = ~fn[0] ^ ~item.top_first;
                                    recs[n] = mk_rec(KIND_BUFFERED, fmt_reg,
                                                     TAG_FIELD1 | {7'd0, f},
                                                     rev8(buf_next[16:9]),
                                                     rev8(buf_next[8:1]), ST_OK);
                                end
                                n = n + 2'd1;
                                buf_next = '0;
                                bits_next = '0;
                                pairs_next = pairs_next - 6'd1;
                                if (pairs_next == 6'd0)
                                begin
                                    recs[n] = mk_rec(KIND_BLKEND, fmt_reg, 8'h00, 8'h00,
                                                     8'h00, ST_OK);
                                    n = n + 2'd1;
                                    phase_next = PH_DONE_OK;
                                end
                            end
                        end
                    end
                end
                PH_TAIL:
                begin
                    if (idx_reg == 4'd2)
                    begin
                        held_next[2] = b;
                    end
                    if (idx_reg == 4'd3)
                    begin
                        recs[n] = mk_rec(KIND_DIRECT, fmt_reg, TAG_FIELD1, held_reg[2], b,
                                         ST_OK);
                        n = n + 2'd1;
                        phase_next = PH_DONE_OK;
                    end
                    idx_next = idx_reg + 4'd1;
                end
                PH_A53_TYPE:
                begin
                    phase_next = (b == 8'h03) ? PH_A53_FLAGS : PH_DONE_OK;
                end
                PH_A53_FLAGS:
                begin
                    sub_next = b;
                    pairs_next = {1'b0, b[4:0]};
                    phase_next = PH_A53_SKIP;
                end
                PH_A53_SKIP:
                begin
                    idx_next = 4'd0;
                    if (!sub_reg[6])
                    begin
                        phase_next = PH_DONE_OK;
                    end
                    else
                    begin
                        phase_next = (pairs_reg == 6'd0) ? PH_A53_MARK : PH_A53_DATA;
                    end
                end
                PH_A53_DATA:
                begin
                    held_next[idx_reg[1:0]] = b;
                    if (idx_reg < 4'd2)
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                    else
                    begin
                        idx_next = 4'd0;
                        recs[n] = mk_rec(KIND_BUFFERED, fmt_reg, held_next[0], held_next[1],
                                         held_next[2], ST_OK);
                        n = n + 2'd1;
                        pairs_next = pairs_reg - 6'd1;
                        if (pairs_next == 6'd0)
                        begin
                            phase_next = PH_A53_MARK;
                        end
                    end
                end
                PH_A53_MARK:
                begin
                    if (b == 8'hFF)
                    begin
                        recs[n] = mk_rec(KIND_BLKEND, fmt_reg, 8'h00, 8'h00, 8'h00, ST_OK);
                        phase_next = PH_DONE_OK;
                    end
                    else
                    begin
                        recs[n] = mk_rec(KIND_BLKEND, fmt_reg, 8'h00, 8'h00, 8'h00, ST_BAD);
                        phase_next = PH_DONE_BAD;
                    end
                    n = n + 2'd1;
                end
                PH_SAT_HDR:
                begin
                    if (idx_reg < 4'd3)
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                    else
                    begin
                        idx_next = 4'd0;
                        sub_next = b;
                        if (b == 8'h02 || b == 8'h04)
                        begin
                            phase_next = PH_SAT_PAD;
                        end
                        else if (b == 8'h05)
                        begin
                            phase_next = PH_SAT_SKIP6;
                        end
                        else
                        begin
                            phase_next = PH_DONE_OK;
                        end
                    end
                end
                PH_SAT_SKIP6:
                begin
                    idx_next = idx_reg + 4'd1;
                    if (idx_next >= 4'd6)
                    begin
                        idx_next = 4'd0;
                        phase_next = PH_SAT_T2;
                    end
                end
                PH_SAT_T2:
                begin
                    sub_next = b;
                    phase_next = PH_SAT_PAD;
                end
                PH_SAT_PAD:
                begin
                    phase_next = PH_SAT_C1;
                end
                PH_SAT_C1:
                begin
                    held_next[0] = b;
                    phase_next = PH_SAT_C2;
                end
                PH_SAT_C2:
                begin
                    held_next[1] = b;
                    recs[n] = mk_rec(KIND_BUFFERED, fmt_reg, TAG_FIELD1, held_reg[0], b,
                                     ST_OK);
                    n = n + 2'd1;
                    phase_next = (sub_reg == 8'h02) ? PH_SAT_REP : PH_SAT_C3;
                end
                PH_SAT_REP:
                begin
                    if (b == 8'h04 && held_reg[0][6:5] == 2'b00)
                    begin
                        recs[n] = mk_rec(KIND_BUFFERED, fmt_reg, TAG_FIELD1, held_reg[0],
                                         held_reg[1], ST_OK);
                        n = n + 2'd1;
                    end
                    recs[n] = mk_rec(KIND_BLKEND, fmt_reg, 8'h00, 8'h00, 8'h00, ST_OK);
                    n = n + 2'd1;
                    phase_next = PH_DONE_OK;
                end
                PH_SAT_C3:
                begin
                    held_next[2] = b;
                    phase_next = PH_SAT_C4;
                end
                PH_SAT_C4:
                begin
                    recs[n] = mk_rec(KIND_BUFFERED, fmt_reg, TAG_FIELD1, held_reg[2], b,
                                     ST_OK);
                    n = n + 2'd1;
                    recs[n] = mk_rec(KIND_BLKEND, fmt_reg, 8'h00, 8'h00, 8'h00, ST_OK);
                    n = n + 2'd1;
                    phase_next = PH_DONE_OK;
                end
                PH_DONE_OK, PH_DONE_BAD:
                begin
                end
                default:
                begin
                end
            endcase
            if (item.last_byte)
            begin
                if (phase_next == PH_DONE_OK)
                begin
                    st = ST_OK;
                end
                else if (phase_next == PH_DONE_BAD)
                begin
                    st = ST_BAD;
                end
                else if (phase_next == PH_DVD_SEG && pairs_next == 6'd0 && !slot_next &&
                         idx_next == 4'd0)
                begin
                    st = ST_OK;
                end
                else
                begin
                    st = ST_TRUNC;
                end
                recs[n] = mk_rec(KIND_DONE, (phase_next == PH_HDR) ? FMT_UNKNOWN : fmt_next,
                                 8'h00, 8'h00, 8'h00, st);
                n = n + 2'd1;
                phase_next = PH_HDR;
                fmt_next = 3'd0;
                idx_next = '0;
                pairs_next = '0;
                buf_next = '0;
                bits_next = '0;
                pat_next = 1'b0;
                trunc_next = 1'b0;
                slot_next = 1'b0;
                sub_next = '0;
            end
        end
        rec_count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            fmt_reg   <= '0;
            idx_reg   <= '0;
            pairs_reg <= '0;
            buf_reg   <= '0;
            bits_reg  <= '0;
            pat_reg   <= 1'b0;
            trunc_reg <= 1'b0;
            slot_reg  <= 1'b0;
            sub_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fmt_reg   <= fmt_next;
            idx_reg   <= idx_next;
            pairs_reg <= pairs_next;
            buf_reg   <= buf_next;
            bits_reg  <= bits_next;
            pat_reg   <= pat_next;
            trunc_reg <= trunc_next;
            slot_reg  <= slot_next;
            sub_reg   <= sub_next;
        end
    end

    // held bytes are written before read; no reset
    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

`ifndef SYNTHESIS
    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg < 5'd26) else $error("scte bit count out of range");
    a_pair_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_SCTE_PAIR) |-> (bits_reg == 5'd0 && buf_reg == '0))
        else $error("bit buffer not clear outside scte");
    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.last_byte) |-> (rec_count != 2'd0))
        else $error("unit end without done record");
`endif

endmodule
`default_nettype wire

[rtl/core/cudp_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cudp_queue
// Result queue: takes up to three records at once, presents one per transfer.
// ----------------------------------------------------------------------------
module cudp_queue
    import cudp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire out_item_t recs [MaxRecords],
    input  wire logic [1:0] rec_count,
    output logic           room,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);

    localparam int PtrW = $clog2(QueueDepth);

    out_item_t         q_reg [QueueDepth];
    logic [PtrW-1:0]   wr_reg, rd_reg;
    logic [PtrW:0]     cnt_reg;
    logic              pop;

    assign pop       = (cnt_reg != '0) && !out_stall;
    assign out_valid = (cnt_reg != '0);
    assign out_data  = q_reg[rd_reg];
    // hold off input unless three free entries are certain
    assign room      = (cnt_reg <= (PtrW+1)'(QueueDepth - MaxRecords));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + PtrW'(rec_count);
            rd_reg  <= rd_reg + PtrW'(pop);
            cnt_reg <= cnt_reg + (PtrW+1)'(rec_count) - (PtrW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MaxRecords; i++)
        begin
            if (2'(i) < rec_count)
            begin
                q_reg[wr_reg + PtrW'(i)] <= recs[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PtrW+1)'(QueueDepth)) else $error("queue overflow");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_count != 2'd0) |-> room) else $error("push without room");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (PtrW+1)'(1) && pop && rec_count == 2'd0) |=> !out_valid)
        else $error("queue did not drain");
`endif

endmodule
`default_nettype wire

[rtl/core/caption_user_data_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// caption_user_data_parser
// Extracts closed-caption pairs from video user-data units.
// ----------------------------------------------------------------------------
// Input channel: one byte of a user-data unit per transfer, with last_byte on
// the final byte and the picture's top_first flag. Output channel: records of
// caption pairs, block ends and one unit-done record per unit.
// Each byte is parsed in the cycle it is transferred; its records (zero to
// three) enter a four-entry queue and appear on the output from the next
// cycle, one per transfer. Throughput: one byte per cycle while each byte
// yields at most one record and the receiver does not stall; a byte yielding
// two or three records holds off input while the queue drains them through
// its single output port.
// in_stall rises while the queue holds more than one record, so a stalled
// receiver backs up the queue, then holds off the sender; nothing is dropped.
// Reset clears the parse state and empties the queue; the first byte after
// reset starts a new unit.
// ----------------------------------------------------------------------------
module caption_user_data_parser
    import cudp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);

    out_item_t  recs [MaxRecords];
    logic [1:0] rec_count;
    logic       room;
    logic       fire;

    // accept a transfer only when the queue can absorb a full burst
    assign in_stall = !room;
    assign fire     = in_valid && room;

    cudp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_data),
        .recs      (recs),
        .rec_count (rec_count)
    );

    cudp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .recs      (recs),
        .rec_count (rec_count),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    a_stall_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (rec_count == 2'd0)) else $error("records while stalled");
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid) else $error("stall with empty queue");
    a_idle_none: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid |-> (rec_count == 2'd0)) else $error("records without input");
`endif

endmodule
`default_nettype wire
